// ----- hw/rtl/sfpb_pkg.sv -----
// Shared types and constants for the sample FIFO packet batcher.
// Used by every module under hw/rtl except sfpb_queue; depends on nothing else.
package sfpb_pkg;

  localparam int FIFO_DEPTH    = 4096;
  localparam int MAX_PACKET    = 1470;
  localparam int PACING_BUDGET = 147000;
  localparam int RESET_PERIOD  = 500;
  localparam int PERIOD_W      = 20;
  localparam int SAMPLE_W      = 8;
  localparam int FILL_W        = 12;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] data_byte;
    logic                data_valid;
    logic                last_of_packet;
    logic                sample_dropped;
    logic [FILL_W-1:0]   fill_level;
  } out_t;

  // What the back end must do for one queued command, and the status it reports.
  typedef struct packed {
    logic wr;
    logic rd;
    logic valid;
    logic last;
    logic dropped;
  } cmd_flags_t;

endpackage

// ----- hw/rtl/sfpb_size_div.sv -----
// Packet size unit: restoring divider of the pacing budget by the sample period.
// Uses sfpb_pkg for the period width and the reset period.
module sfpb_size_div #(
  parameter int MAX_PACKET    = sfpb_pkg::MAX_PACKET,
  parameter int PACING_BUDGET = sfpb_pkg::PACING_BUDGET
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sfpb_pkg::PERIOD_W-1:0] period,
  output logic                          busy,
  output logic [$clog2(MAX_PACKET+1)-1:0] psize
);

  localparam int QW = $clog2(PACING_BUDGET + 1);
  localparam int PW = sfpb_pkg::PERIOD_W;
  localparam int SW = $clog2(MAX_PACKET + 1);
  localparam int CW = $clog2(QW + 1);
  localparam int RESET_Q = PACING_BUDGET / sfpb_pkg::RESET_PERIOD;
  localparam int RESET_SIZE = (RESET_Q > MAX_PACKET) ? MAX_PACKET :
                              ((RESET_Q < 1) ? 1 : RESET_Q);

  logic [CW-1:0] cnt;
  logic [PW-1:0] rem;
  logic [PW-1:0] divisor;
  logic [QW-1:0] quo;

  logic [PW:0]   trial;
  logic          qbit;
  logic [PW-1:0] rem_next;
  logic [QW-1:0] quo_next;

  always_comb begin
    trial    = {rem, quo[QW-1]};
    qbit     = (trial >= {1'b0, divisor});
    rem_next = qbit ? PW'(trial - {1'b0, divisor}) : PW'(trial);
    quo_next = QW'({quo, qbit});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      psize <= SW'(RESET_SIZE);
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt + CW'(1);
      if (cnt == CW'(QW - 1)) begin
        busy <= 1'b0;
        if (32'(quo_next) > 32'(MAX_PACKET)) begin
          psize <= SW'(MAX_PACKET);
        end else if (quo_next == '0) begin
          psize <= SW'(1);
        end else begin
          psize <= SW'(quo_next);
        end
      end
    end else if (start) begin
      // A zero period saturates the quotient, so the size goes straight to the cap.
      if (period == '0) begin
        psize <= SW'(MAX_PACKET);
      end else begin
        busy    <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        divisor <= period;
        quo     <= QW'(PACING_BUDGET);
      end
    end
  end

endmodule

// ----- hw/rtl/sfpb_front.sv -----
// Front end: accepts items, tracks ring indices, fill and packet progress,
// and issues one memory command per item. Uses sfpb_pkg types.
module sfpb_front #(
  parameter int FIFO_DEPTH = sfpb_pkg::FIFO_DEPTH,
  parameter int MAX_PACKET = sfpb_pkg::MAX_PACKET
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sfpb_pkg::in_t                    in_item,
  input  logic [$clog2(MAX_PACKET+1)-1:0]  psize,
  input  logic                             hold,
  input  logic                             q_full,
  output logic                             q_push,
  output sfpb_pkg::cmd_flags_t             cmd_flags,
  output logic [$clog2(FIFO_DEPTH)-1:0]    cmd_addr,
  output logic [sfpb_pkg::SAMPLE_W-1:0]    cmd_sample,
  output logic [sfpb_pkg::FILL_W-1:0]      cmd_fill
);

  localparam int AW   = $clog2(FIFO_DEPTH);
  localparam int SW   = $clog2(MAX_PACKET + 1);
  localparam int CMPW = (AW > SW) ? AW : SW;

  logic [AW-1:0] wr_idx, rd_idx, fill;
  logic [SW-1:0] left;

  logic [AW-1:0] wr_idx_next, rd_idx_next, fill_next;
  logic [SW-1:0] left_next;
  logic          full, start, do_write, do_read, take;
  logic [SW-1:0] left_eff;

  assign in_ready = !q_full && !hold;
  assign take     = in_valid && in_ready;
  assign q_push   = take;

  always_comb begin
    full  = (fill == AW'(FIFO_DEPTH - 1));
    start = (left == '0) && (CMPW'(fill) >= CMPW'(psize));
    left_eff = start ? psize : left;
    do_write = (in_item.op == sfpb_pkg::OP_PUSH) && !full;
    do_read  = (in_item.op == sfpb_pkg::OP_PULL) && (left_eff != '0) && (fill != '0);

    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx;
    fill_next   = fill;
    left_next   = left;
    if (do_write) begin
      wr_idx_next = (wr_idx == AW'(FIFO_DEPTH - 1)) ? '0 : wr_idx + AW'(1);
      fill_next   = fill + AW'(1);
    end
    if (in_item.op == sfpb_pkg::OP_PULL) begin
      left_next = left_eff;
      if (do_read) begin
        rd_idx_next = (rd_idx == AW'(FIFO_DEPTH - 1)) ? '0 : rd_idx + AW'(1);
        fill_next   = fill - AW'(1);
        left_next   = left_eff - SW'(1);
      end
    end

    cmd_flags.wr      = do_write;
    cmd_flags.rd      = do_read;
    cmd_flags.valid   = do_read;
    cmd_flags.last    = do_read && (left_eff == SW'(1));
    cmd_flags.dropped = (in_item.op == sfpb_pkg::OP_PUSH) && full;
    cmd_addr          = do_write ? wr_idx : rd_idx;
    cmd_sample        = in_item.sample;
    cmd_fill          = sfpb_pkg::FILL_W'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      fill   <= '0;
      left   <= '0;
    end else if (take) begin
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
      fill   <= fill_next;
      left   <= left_next;
    end
  end

endmodule

// ----- hw/rtl/sfpb_queue.sv -----
// Short command queue between the front and back ends.
// Generic width; depth is a power of two. No package dependencies.
module sfpb_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int PTR = $clog2(DEPTH);

  logic [W-1:0]   slots [DEPTH];
  logic [PTR-1:0] wr_ptr, rd_ptr;
  logic [PTR:0]   count;

  assign full  = (count == (PTR+1)'(DEPTH));
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR+1)'(1);
        2'b01:   count <= count - (PTR+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sfpb_back.sv -----
// Back end: sample memory and output register. Executes queued writes and reads
// in order and presents one result beat per command. Uses sfpb_pkg types.
module sfpb_back #(
  parameter int FIFO_DEPTH = sfpb_pkg::FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  sfpb_pkg::cmd_flags_t          cmd_flags,
  input  logic [$clog2(FIFO_DEPTH)-1:0] cmd_addr,
  input  logic [sfpb_pkg::SAMPLE_W-1:0] cmd_sample,
  input  logic [sfpb_pkg::FILL_W-1:0]   cmd_fill,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sfpb_pkg::out_t                out_item
);

  logic [sfpb_pkg::SAMPLE_W-1:0] mem [FIFO_DEPTH];
  logic [sfpb_pkg::SAMPLE_W-1:0] rdata;
  sfpb_pkg::cmd_flags_t          flags;
  logic [sfpb_pkg::FILL_W-1:0]   fill;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (q_pop && cmd_flags.wr) begin
      mem[cmd_addr] <= cmd_sample;
    end
    if (q_pop && cmd_flags.rd) begin
      rdata <= mem[cmd_addr];
    end
    if (q_pop) begin
      flags <= cmd_flags;
      fill  <= cmd_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The read data register only changes on a read, so it stays put while stalled.
  always_comb begin
    out_item.data_byte      = flags.valid ? rdata : '0;
    out_item.data_valid     = flags.valid;
    out_item.last_of_packet = flags.last;
    out_item.sample_dropped = flags.dropped;
    out_item.fill_level     = fill;
  end

endmodule

// ----- hw/rtl/sample_fifo_packet_batcher_core.sv -----
// Sample FIFO packet batcher, top level: ring FIFO of 8-bit samples drained in
// fixed-size packets. Instantiates sfpb_size_div, sfpb_front, sfpb_queue and sfpb_back.
//
// Each push or pull beat yields exactly one result beat, in order. The block
// sustains one item per cycle while the command queue has room and no size update
// runs; a result is registered in the command queue and then in the back end's
// output register. The four-entry command queue between the bookkeeping front
// end and the memory back end lets either side stall alone. A write of the period
// register starts a bit-per-cycle divider; input beats are held off until the new
// packet size is in place. A period of zero takes effect at once with the maximum
// packet size. The FIFO keeps one slot empty, so it holds at most FIFO_DEPTH-1
// samples; the sample memory is a single-port array written or read once per cycle.
module sample_fifo_packet_batcher_core #(
  parameter int FIFO_DEPTH    = sfpb_pkg::FIFO_DEPTH,
  parameter int MAX_PACKET    = sfpb_pkg::MAX_PACKET,
  parameter int PACING_BUDGET = sfpb_pkg::PACING_BUDGET
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sfpb_pkg::in_t                 in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sfpb_pkg::out_t                out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfpb_pkg::PERIOD_W-1:0] cfg_data
);

  localparam int AW    = $clog2(FIFO_DEPTH);
  localparam int SW    = $clog2(MAX_PACKET + 1);
  localparam int FW    = $bits(sfpb_pkg::cmd_flags_t);
  localparam int CMD_W = FW + AW + sfpb_pkg::SAMPLE_W + sfpb_pkg::FILL_W;

  logic                          div_busy;
  logic [SW-1:0]                 psize;
  logic                          q_push, q_full, q_pop, q_valid;
  sfpb_pkg::cmd_flags_t          f_flags, b_flags;
  logic [AW-1:0]                 f_addr, b_addr;
  logic [sfpb_pkg::SAMPLE_W-1:0] f_sample, b_sample;
  logic [sfpb_pkg::FILL_W-1:0]   f_fill, b_fill;
  logic [CMD_W-1:0]              q_wdata, q_rdata;

  assign cfg_ready = !div_busy;

  sfpb_size_div #(
    .MAX_PACKET   (MAX_PACKET),
    .PACING_BUDGET(PACING_BUDGET)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_valid),
    .period(cfg_data),
    .busy  (div_busy),
    .psize (psize)
  );

  sfpb_front #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .MAX_PACKET(MAX_PACKET)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .psize     (psize),
    .hold      (div_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .cmd_flags (f_flags),
    .cmd_addr  (f_addr),
    .cmd_sample(f_sample),
    .cmd_fill  (f_fill)
  );

  assign q_wdata = {f_flags, f_addr, f_sample, f_fill};
  assign {b_flags, b_addr, b_sample, b_fill} = q_rdata;

  sfpb_queue #(
    .W    (CMD_W),
    .DEPTH(sfpb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .rdata(q_rdata)
  );

  sfpb_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .cmd_flags (b_flags),
    .cmd_addr  (b_addr),
    .cmd_sample(b_sample),
    .cmd_fill  (b_fill),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_last_has_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last_of_packet |-> out_item.data_valid)
    else $error("last_of_packet without a packet byte");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.data_valid |-> out_item.data_byte == '0)
    else $error("nonzero data_byte on a beat without a packet byte");

  a_drop_not_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.sample_dropped |-> !out_item.data_valid)
    else $error("a beat both dropped a sample and returned a byte");

  a_size_update_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_data != '0) |=> !in_ready)
    else $error("input taken while the packet size was being recomputed");

endmodule
